// ----- rtl/bdm_pkg.sv -----
// ---------------------------------------------------------------------------
// bdm_pkg
// Shared types and constants for the birth-death-mutation SSA step block.
// ---------------------------------------------------------------------------
package bdm_pkg;

    localparam int TOT_W = 48;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    // request codes
    localparam logic [1:0] REQ_LOAD_TRAIT = 2'd0;
    localparam logic [1:0] REQ_LOAD_COMP  = 2'd1;
    localparam logic [1:0] REQ_RECOMPUTE  = 2'd2;
    localparam logic [1:0] REQ_STEP       = 2'd3;

    // configuration register indexes
    localparam logic CFG_TRAIT_COUNT = 1'b0;
    localparam logic CFG_MUT_PROB    = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_B_RD,
        ST_B_MUL,
        ST_B_MS,
        ST_B_WR,
        ST_B_LAST,
        ST_D_HEAD,
        ST_D_HEAD2,
        ST_D_LOOP,
        ST_D_MLO,
        ST_D_MHI,
        ST_D_WR,
        ST_D_SUM,
        ST_W_MUL,
        ST_W_RD,
        ST_W_CMP,
        ST_K_MUL,
        ST_K_DEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_we;   // write count, birth and death rate of one trait
        logic cnt_we;    // write count only
        logic comp_we;   // write one competition entry
    } t_tab_ctl;

    typedef struct packed {
        logic bt_we;
        logic dt_we;
    } t_tot_ctl;

endpackage

// ----- rtl/bdm_tables.sv -----
// ---------------------------------------------------------------------------
// bdm_tables
// Per-trait tables (count, birth rate, death rate) and competition matrix.
// ---------------------------------------------------------------------------
module bdm_tables #(
    parameter int MAX_TRAITS = 64,
    parameter int COUNT_BITS = 20,
    localparam int TW = $clog2(MAX_TRAITS),
    localparam int MW = $clog2(MAX_TRAITS * MAX_TRAITS)
) (
    input  logic              i_clk,
    input  bdm_pkg::t_tab_ctl i_ctl,
    input  logic [TW-1:0]     i_waddr,
    input  logic [COUNT_BITS-1:0] i_m_wdata,
    input  logic [31:0]       i_b_wdata,
    input  logic [31:0]       i_d_wdata,
    input  logic [MW-1:0]     i_c_waddr,
    input  logic [31:0]       i_c_wdata,
    input  logic [TW-1:0]     i_raddr,
    input  logic [MW-1:0]     i_c_raddr,
    output logic [COUNT_BITS-1:0] o_m_rdata,
    output logic [31:0]       o_b_rdata,
    output logic [31:0]       o_d_rdata,
    output logic [31:0]       o_c_rdata
);
    import bdm_pkg::*;

    logic [COUNT_BITS-1:0] mem_m [MAX_TRAITS];
    logic [31:0]           mem_b [MAX_TRAITS];
    logic [31:0]           mem_d [MAX_TRAITS];
    logic [31:0]           mem_c [MAX_TRAITS*MAX_TRAITS];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_we || i_ctl.cnt_we) begin
            mem_m[i_waddr] <= i_m_wdata;
        end
        if (i_ctl.load_we) begin
            mem_b[i_waddr] <= i_b_wdata;
            mem_d[i_waddr] <= i_d_wdata;
        end
        o_m_rdata <= mem_m[i_raddr];
        o_b_rdata <= mem_b[i_raddr];
        o_d_rdata <= mem_d[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.comp_we) begin
            mem_c[i_c_waddr] <= i_c_wdata;
        end
        o_c_rdata <= mem_c[i_c_raddr];
    end

endmodule

// ----- rtl/bdm_totals.sv -----
// ---------------------------------------------------------------------------
// bdm_totals
// Per-trait birth and death totals; entries read as zero until written.
// ---------------------------------------------------------------------------
module bdm_totals #(
    parameter int MAX_TRAITS = 64,
    localparam int TW = $clog2(MAX_TRAITS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdm_pkg::t_tot_ctl i_ctl,
    input  logic [TW-1:0]     i_bt_waddr,
    input  logic [47:0]       i_bt_wdata,
    input  logic [TW-1:0]     i_dt_waddr,
    input  logic [47:0]       i_dt_wdata,
    input  logic [TW-1:0]     i_raddr,
    output logic [47:0]       o_bt_rdata,
    output logic [47:0]       o_dt_rdata
);
    import bdm_pkg::*;

    logic [47:0] mem_bt [MAX_TRAITS];
    logic [47:0] mem_dt [MAX_TRAITS];
    logic [MAX_TRAITS-1:0] r_bt_vld;
    logic [MAX_TRAITS-1:0] r_dt_vld;
    logic [47:0] r_bt_rd;
    logic [47:0] r_dt_rd;
    logic        r_bt_rv;
    logic        r_dt_rv;

    always_ff @(posedge i_clk) begin
        if (i_ctl.bt_we) begin
            mem_bt[i_bt_waddr] <= i_bt_wdata;
        end
        if (i_ctl.dt_we) begin
            mem_dt[i_dt_waddr] <= i_dt_wdata;
        end
        r_bt_rd <= mem_bt[i_raddr];
        r_dt_rd <= mem_dt[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bt_vld <= '0;
            r_dt_vld <= '0;
            r_bt_rv  <= 1'b0;
            r_dt_rv  <= 1'b0;
        end else begin
            if (i_ctl.bt_we) begin
                r_bt_vld[i_bt_waddr] <= 1'b1;
            end
            if (i_ctl.dt_we) begin
                r_dt_vld[i_dt_waddr] <= 1'b1;
            end
            r_bt_rv <= r_bt_vld[i_raddr];
            r_dt_rv <= r_dt_vld[i_raddr];
        end
    end

    assign o_bt_rdata = r_bt_rv ? r_bt_rd : '0;
    assign o_dt_rdata = r_dt_rv ? r_dt_rd : '0;

endmodule

// ----- rtl/birth_death_mutation_ssa_step.sv -----
// ---------------------------------------------------------------------------
// birth_death_mutation_ssa_step
// Gillespie direct-method step for a chain of trait populations.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one item per request:
//   load trait, load competition entry, recompute totals, or step.
//   Loads are written while idle and give no result. Recompute and step
//   each give one result item on the output channel (o_out_valid /
//   i_out_stall), held in an output register until taken.
//   Work per item, with n traits in use:
//     rebuild of all totals = birth totals of every trait, then death
//       totals; the death totals walk the n x n competition matrix one
//       entry per cycle through the single read port of the matrix memory.
//     recompute = rebuild + completion state.
//     step = pick scale, walk to the picked trait, event decision, plus a
//       rebuild before the completion state if the count moved.
//   The block works on one item at a time; o_in_stall is high while busy.
//   A finished result waits in the output register; the next item is taken
//   while it waits, and a new result waits for the slot to free.
//   Reset: totals read as zero, event total zero, trait_count 2, mutation 0.
//   Tables and matrix hold nothing useful until loaded.
//   Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata.
// ---------------------------------------------------------------------------
module birth_death_mutation_ssa_step #(
    parameter int MAX_TRAITS = 64,
    parameter int COUNT_BITS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [5:0]  i_row_index,
    input  logic [5:0]  i_col_index,
    input  logic [19:0] i_member_value,
    input  logic [31:0] i_birth_value,
    input  logic [31:0] i_death_value,
    input  logic [31:0] i_comp_value,
    input  logic [15:0] i_uniform_pick,
    input  logic [15:0] i_uniform_kind,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_chosen_trait,
    output logic        o_is_birth,
    output logic        o_count_changed,
    output logic [19:0] o_new_members,
    output logic [47:0] o_total_rate,
    output logic        o_saturated
);
    import bdm_pkg::*;

    localparam int TW  = $clog2(MAX_TRAITS);
    localparam int NW  = $clog2(MAX_TRAITS + 1);
    localparam int MW  = $clog2(MAX_TRAITS * MAX_TRAITS);
    localparam int CW  = COUNT_BITS;
    localparam int MBW = CW + 32;          // count times rate
    localparam int FW  = 48 + CW + 1;      // inner total times count
    localparam logic [CW-1:0] CNT_MAX = '1;

    // configuration
    logic [6:0]  r_trait_count;
    logic [15:0] r_mut;

    // sequencer state
    t_state r_state, n_state;
    logic [NW-1:0]  r_k, n_k;
    logic [NW-1:0]  r_j, n_j;
    logic [TW-1:0]  r_pick, n_pick;
    logic [MBW-1:0] r_mb, n_mb;
    logic [47:0]    r_own_new, n_own_new, r_ms_new, n_ms_new;
    logic [47:0]    r_own_cur, n_own_cur, r_ms_cur, n_ms_cur, r_ms_prev, n_ms_prev;
    logic [CW-1:0]  r_m, n_m;
    logic [47:0]    r_inner, n_inner;
    logic           r_isat, n_isat;
    logic [47:0]    r_bt, n_bt, r_dt, n_dt;
    logic           r_p1_v, n_p1_v, r_p2_v, n_p2_v;
    logic [31+CW:0] r_prod, n_prod;
    logic [23+CW:0] r_pl, n_pl, r_ph, n_ph;
    logic [47:0]    r_esum, n_esum;
    logic [47:0]    r_event, n_event;
    logic [15:0]    r_up, n_up, r_uk, n_uk;
    logic [47:0]    r_left, n_left;
    logic [48:0]    r_rate, n_rate;
    logic [48:0]    r_kind, n_kind;
    logic           r_birth, n_birth, r_changed, n_changed, r_sat, n_sat;
    logic [CW-1:0]  r_newm, n_newm;

    // output register
    logic        r_out_valid;
    logic [5:0]  r_o_trait;
    logic        r_o_birth, r_o_changed, r_o_sat;
    logic [19:0] r_o_members;
    logic [47:0] r_o_total;

    // memory ports
    t_tab_ctl      tab_ctl;
    t_tot_ctl      tot_ctl;
    logic [TW-1:0] tab_waddr, tab_raddr, tot_raddr, bt_waddr;
    logic [CW-1:0] m_wdata;
    logic [MW-1:0] c_waddr, c_raddr;
    logic [47:0]   bt_wdata;
    logic [CW-1:0] m_rdata;
    logic [31:0]   b_rdata, d_rdata, c_rdata;
    logic [47:0]   bt_rdata, dt_rdata;

    // combinational helpers
    logic          in_fire, out_free;
    logic [NW-1:0] n_used;
    logic          row_ok, col_ok;
    logic [49:0]   bsum;
    logic [MBW+15:0] ms_full;
    logic [48:0]   acc_sum;
    logic [FW-1:0] dfull;
    logic [48:0]   pair, esum_full;
    logic [47:0]   pair_c;
    logic [48:0]   walk_rate;
    logic          walk_hit;
    logic          k_birth, k_changed, k_full;
    logic [CW-1:0] k_new;
    logic [63:0]   left_full;
    logic [64:0]   kind_full;

    assign in_fire  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // traits in use, clamped to 2..MAX_TRAITS
    always_comb begin
        if (r_trait_count < 7'd2) begin
            n_used = NW'(2);
        end else if (int'(r_trait_count) > MAX_TRAITS) begin
            n_used = NW'(MAX_TRAITS);
        end else begin
            n_used = NW'(r_trait_count);
        end
    end

    assign row_ok = int'(i_row_index) < MAX_TRAITS;
    assign col_ok = int'(i_col_index) < MAX_TRAITS;

    // birth total of trait j-1 (or n-1 at the tail): own + the shares of the neighbors it has
    assign bsum = 50'(r_own_cur) + 50'(r_ms_prev)
                + ((r_state == ST_B_WR) ? 50'(r_ms_new) : 50'd0);
    // neighbor share: floor(mb * mu / 2^17)
    assign ms_full = (MBW+16)'((r_mb * r_mut) >> 17);
    // competition accumulate
    assign acc_sum = 49'(r_inner)
                   + ((r_prod > (32+CW)'(TOT_MAX)) ? 49'(TOT_MAX) : 49'(r_prod));
    assign dfull = (FW'(r_ph) << 24) + FW'(r_pl);
    assign pair = 49'(r_bt) + 49'(r_dt);
    assign pair_c = (pair > 49'(TOT_MAX)) ? TOT_MAX : pair[47:0];
    assign esum_full = 49'(r_esum) + 49'(pair_c);

    assign walk_rate = 49'(bt_rdata) + 49'(dt_rdata);
    assign walk_hit  = (49'(r_left) <= walk_rate) || (r_k == n_used - NW'(1));

    assign left_full = 64'(r_event) * 64'(r_up);
    assign kind_full = 65'(r_rate) * 65'(r_uk);

    // birth or death on the picked trait
    always_comb begin
        k_birth = 49'(r_kind) < 49'(r_bt);
        k_full  = (m_rdata == CNT_MAX);
        if (k_birth) begin
            k_changed = !k_full;
            k_new     = k_full ? m_rdata : m_rdata + CW'(1);
        end else begin
            k_changed = (m_rdata != '0);
            k_new     = k_changed ? m_rdata - CW'(1) : m_rdata;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_req_type == REQ_RECOMPUTE) begin
                    n_state = ST_B_RD;
                end else if (in_fire && i_req_type == REQ_STEP) begin
                    n_state = ST_W_MUL;
                end
            end
            ST_B_RD:    n_state = ST_B_MUL;
            ST_B_MUL:   n_state = ST_B_MS;
            ST_B_MS:    n_state = ST_B_WR;
            ST_B_WR: begin
                if ((NW+1)'(r_j) + (NW+1)'(1) < (NW+1)'(n_used)) begin
                    n_state = ST_B_RD;
                end else begin
                    n_state = ST_B_LAST;
                end
            end
            ST_B_LAST:  n_state = ST_D_HEAD;
            ST_D_HEAD:  n_state = ST_D_HEAD2;
            ST_D_HEAD2: n_state = ST_D_LOOP;
            ST_D_LOOP: begin
                if (r_j >= n_used && !r_p1_v && !r_p2_v) begin
                    n_state = ST_D_MLO;
                end
            end
            ST_D_MLO:   n_state = ST_D_MHI;
            ST_D_MHI:   n_state = ST_D_WR;
            ST_D_WR:    n_state = ST_D_SUM;
            ST_D_SUM: begin
                if ((NW+1)'(r_k) + (NW+1)'(1) < (NW+1)'(n_used)) begin
                    n_state = ST_D_HEAD;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_W_MUL:   n_state = ST_W_RD;
            ST_W_RD:    n_state = ST_W_CMP;
            ST_W_CMP:   n_state = walk_hit ? ST_K_MUL : ST_W_RD;
            ST_K_MUL:   n_state = ST_K_DEC;
            ST_K_DEC:   n_state = k_changed ? ST_B_RD : ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:    n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        tab_ctl.load_we = in_fire && (i_req_type == REQ_LOAD_TRAIT) && row_ok;
        tab_ctl.comp_we = in_fire && (i_req_type == REQ_LOAD_COMP) && row_ok && col_ok;
        tab_ctl.cnt_we  = (r_state == ST_K_DEC) && k_changed;
        tab_waddr = (r_state == ST_K_DEC) ? r_pick : TW'(i_row_index);
        m_wdata   = (r_state == ST_K_DEC) ? k_new : CW'(i_member_value);
        c_waddr   = MW'(int'(i_row_index) * MAX_TRAITS + int'(i_col_index));
        c_raddr   = MW'(int'(r_k) * MAX_TRAITS + int'(r_j));
        case (r_state)
            ST_B_RD:   tab_raddr = TW'(r_j);
            ST_D_HEAD: tab_raddr = TW'(r_k);
            ST_D_LOOP: tab_raddr = TW'(r_j);
            ST_K_MUL:  tab_raddr = r_pick;
            default:   tab_raddr = '0;
        endcase
        tot_ctl.bt_we = ((r_state == ST_B_WR) && (r_j != '0)) || (r_state == ST_B_LAST);
        tot_ctl.dt_we = (r_state == ST_D_WR);
        bt_waddr = (r_state == ST_B_LAST) ? TW'(n_used - NW'(1)) : TW'(r_j - NW'(1));
        bt_wdata = (bsum > 50'(TOT_MAX)) ? TOT_MAX : bsum[47:0];
        tot_raddr = TW'(r_k);
    end

    // datapath
    always_comb begin
        n_k = r_k;  n_j = r_j;  n_pick = r_pick;  n_mb = r_mb;
        n_own_new = r_own_new;  n_ms_new = r_ms_new;
        n_own_cur = r_own_cur;  n_ms_cur = r_ms_cur;  n_ms_prev = r_ms_prev;
        n_m = r_m;  n_inner = r_inner;  n_isat = r_isat;
        n_bt = r_bt;  n_dt = r_dt;  n_p1_v = 1'b0;  n_p2_v = 1'b0;
        n_prod = r_prod;  n_pl = r_pl;  n_ph = r_ph;
        n_esum = r_esum;  n_event = r_event;
        n_up = r_up;  n_uk = r_uk;  n_left = r_left;  n_rate = r_rate;
        n_kind = r_kind;  n_birth = r_birth;  n_changed = r_changed;
        n_sat = r_sat;  n_newm = r_newm;
        case (r_state)
            ST_IDLE: begin
                n_j = '0;  n_ms_cur = '0;  n_esum = '0;  n_k = '0;
                n_sat = 1'b0;
                n_pick = '0;  n_birth = 1'b0;  n_changed = 1'b0;  n_newm = '0;
                n_up = i_uniform_pick;
                n_uk = i_uniform_kind;
            end
            ST_B_MUL: n_mb = MBW'(m_rdata) * MBW'(b_rdata);
            ST_B_MS: begin
                n_own_new = (r_mb > MBW'(TOT_MAX)) ? TOT_MAX : 48'(r_mb);
                n_ms_new  = (ms_full > (MBW+16)'(TOT_MAX)) ? TOT_MAX : 48'(ms_full);
                if (r_mb > MBW'(TOT_MAX) || ms_full > (MBW+16)'(TOT_MAX)) begin
                    n_sat = 1'b1;
                end
            end
            ST_B_WR: begin
                if (r_j != '0 && bsum > 50'(TOT_MAX)) begin
                    n_sat = 1'b1;
                end
                n_ms_prev = r_ms_cur;
                n_own_cur = r_own_new;
                n_ms_cur  = r_ms_new;
                n_j = r_j + NW'(1);
            end
            ST_B_LAST: begin
                if (bsum > 50'(TOT_MAX)) begin
                    n_sat = 1'b1;
                end
                n_k = '0;
            end
            ST_D_HEAD2: begin
                n_m = m_rdata;
                n_inner = 48'(d_rdata);
                n_bt = bt_rdata;
                n_isat = 1'b0;
                n_j = '0;
            end
            ST_D_LOOP: begin
                if (r_j < n_used) begin
                    n_j = r_j + NW'(1);
                    n_p1_v = 1'b1;
                end
                if (r_p1_v) begin
                    n_prod = (32+CW)'(c_rdata) * (32+CW)'(m_rdata);
                end
                n_p2_v = r_p1_v;
                if (r_p2_v) begin
                    if (r_prod > (32+CW)'(TOT_MAX) || acc_sum > 49'(TOT_MAX)) begin
                        n_isat = 1'b1;
                    end
                    n_inner = (acc_sum > 49'(TOT_MAX)) ? TOT_MAX : acc_sum[47:0];
                end
            end
            ST_D_MLO: n_pl = (24+CW)'(r_inner[23:0]) * (24+CW)'(r_m);
            ST_D_MHI: n_ph = (24+CW)'(r_inner[47:24]) * (24+CW)'(r_m);
            ST_D_WR: begin
                if (r_m == '0) begin
                    n_dt = '0;
                end else begin
                    n_dt = (dfull > FW'(TOT_MAX)) ? TOT_MAX : 48'(dfull);
                    if (r_isat || dfull > FW'(TOT_MAX)) begin
                        n_sat = 1'b1;
                    end
                end
            end
            ST_D_SUM: begin
                if (pair > 49'(TOT_MAX) || esum_full > 49'(TOT_MAX)) begin
                    n_sat = 1'b1;
                end
                n_esum = (esum_full > 49'(TOT_MAX)) ? TOT_MAX : esum_full[47:0];
                n_event = n_esum;
                n_k = r_k + NW'(1);
            end
            ST_W_MUL: begin
                n_left = left_full[63:16];
                n_k = '0;
            end
            ST_W_CMP: begin
                if (walk_hit) begin
                    n_pick = TW'(r_k);
                    n_rate = walk_rate;
                    n_bt = bt_rdata;
                end else begin
                    n_left = 48'(49'(r_left) - walk_rate);
                    n_k = r_k + NW'(1);
                end
            end
            ST_K_MUL: n_kind = kind_full[64:16];
            ST_K_DEC: begin
                n_birth = k_birth;
                n_changed = k_changed;
                n_newm = k_new;
                if (k_birth && k_full) begin
                    n_sat = 1'b1;
                end
                n_j = '0;  n_ms_cur = '0;  n_esum = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_trait_count <= 7'd2;
            r_mut         <= '0;
            r_event       <= '0;
            r_out_valid   <= 1'b0;
            r_p1_v        <= 1'b0;
            r_p2_v        <= 1'b0;
        end else begin
            r_state <= n_state;
            r_event <= n_event;
            r_p1_v  <= n_p1_v;
            r_p2_v  <= n_p2_v;
            if (i_cfg_we && i_cfg_index == CFG_TRAIT_COUNT) begin
                r_trait_count <= i_cfg_wdata[6:0];
            end
            if (i_cfg_we && i_cfg_index == CFG_MUT_PROB) begin
                r_mut <= i_cfg_wdata;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k <= n_k;  r_j <= n_j;  r_pick <= n_pick;  r_mb <= n_mb;
        r_own_new <= n_own_new;  r_ms_new <= n_ms_new;
        r_own_cur <= n_own_cur;  r_ms_cur <= n_ms_cur;  r_ms_prev <= n_ms_prev;
        r_m <= n_m;  r_inner <= n_inner;  r_isat <= n_isat;
        r_bt <= n_bt;  r_dt <= n_dt;  r_prod <= n_prod;
        r_pl <= n_pl;  r_ph <= n_ph;  r_esum <= n_esum;
        r_up <= n_up;  r_uk <= n_uk;  r_left <= n_left;  r_rate <= n_rate;
        r_kind <= n_kind;  r_birth <= n_birth;  r_changed <= n_changed;
        r_sat <= n_sat;  r_newm <= n_newm;
        if (r_state == ST_DONE && out_free) begin
            r_o_trait   <= 6'(r_pick);
            r_o_birth   <= r_birth;
            r_o_changed <= r_changed;
            r_o_members <= 20'(r_newm);
            r_o_total   <= r_event;
            r_o_sat     <= r_sat;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_chosen_trait  = r_o_trait;
    assign o_is_birth      = r_o_birth;
    assign o_count_changed = r_o_changed;
    assign o_new_members   = r_o_members;
    assign o_total_rate    = r_o_total;
    assign o_saturated     = r_o_sat;

    bdm_tables #(
        .MAX_TRAITS (MAX_TRAITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_tables (
        .i_clk     (i_clk),
        .i_ctl     (tab_ctl),
        .i_waddr   (tab_waddr),
        .i_m_wdata (m_wdata),
        .i_b_wdata (i_birth_value),
        .i_d_wdata (i_death_value),
        .i_c_waddr (c_waddr),
        .i_c_wdata (i_comp_value),
        .i_raddr   (tab_raddr),
        .i_c_raddr (c_raddr),
        .o_m_rdata (m_rdata),
        .o_b_rdata (b_rdata),
        .o_d_rdata (d_rdata),
        .o_c_rdata (c_rdata)
    );

    bdm_totals #(
        .MAX_TRAITS (MAX_TRAITS)
    ) u_totals (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tot_ctl),
        .i_bt_waddr (bt_waddr),
        .i_bt_wdata (bt_wdata),
        .i_dt_waddr (TW'(r_k)),
        .i_dt_wdata (n_dt),
        .i_raddr    (tot_raddr),
        .o_bt_rdata (bt_rdata),
        .o_dt_rdata (dt_rdata)
    );

    // result only appears out of the completion state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised outside completion");

    // the matrix walk never issues past the traits in use
    a_loop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_D_LOOP) |-> (r_j <= n_used))
        else $error("competition walk overran");

    // an event either rebuilds or finishes
    a_event_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_K_DEC) |=> (r_state == ST_B_RD || r_state == ST_DONE))
        else $error("bad state after event");

endmodule
